// ----- rtl/dhst_pkg.sv -----
package dhst_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int HANDLE_BITS = 32;
   localparam int KIND_BITS   = 8;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] OP_STORE = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_BAD_INDEX = 2'd1;
   localparam logic [1:0] STS_NOT_ALLOC = 2'd2;
   localparam logic [1:0] STS_FULL      = 2'd3;

   typedef struct packed {
      logic [1:0]             opcode;
      logic [HANDLE_BITS-1:0] obj_handle;
      logic [KIND_BITS-1:0]   entry_kind;
      logic [5:0]             slot_index;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [5:0]             slot_out;
      logic [HANDLE_BITS-1:0] handle_out;
      logic [KIND_BITS-1:0]   kind_out;
   } rsp_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]   kind;
      logic [HANDLE_BITS-1:0] handle;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_LOAD
   } state_type;

endpackage

// ----- rtl/dedup_handle_slot_table_top.sv -----
// channel | ports                      | handshake
// --------+----------------------------+-------------------------------------
// request | start, busy, req_data      | beat taken when start & !busy
// result  | rsp_valid, rsp_data        | one-cycle strobe, cannot be held off
//
// Store: busy through ST_SCAN (skipped on an empty table) and ST_FINISH, one table
// entry per cycle through the single read port of the entry memory and one shared
// handle/kind comparator. A duplicate hit ends the scan early. Load: busy in
// ST_LOAD (registered memory read). Clear and unknown opcodes: no busy time. The
// result strobes in the first cycle with busy low (the cycle after accept for clear).
// Reset empties the table at once (valid bits in flops); entry memory is not cleared.
module dedup_handle_slot_table_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dhst_pkg::req_type req_data,
   output logic             rsp_valid,
   output dhst_pkg::rsp_type rsp_data
);
   import dhst_pkg::*;

   state_type              state_ff, state_in;
   req_type                hold_ff, hold_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [CNT_W-1:0]       scan_addr_ff, scan_addr_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                   have_free_ff, have_free_in;
   logic [IDX_W-1:0]       free_slot_ff, free_slot_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   entry_type              mem_ff [TABLE_DEPTH];
   entry_type              rd_data_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   entry_type              wr_data;

   logic                   accept;
   logic                   hit;
   logic                   free_here;
   logic                   last_cmp;
   logic                   issue;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign rd_addr = (state_ff == ST_SCAN) ? scan_addr_ff[IDX_W-1:0] : req_data.slot_index;
   assign wr_data = '{kind: hold_ff.entry_kind, handle: hold_ff.obj_handle};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   // compare stage sees the entry read in the previous cycle
   assign hit = cmp_vld_ff && valid_ff[cmp_idx_ff] && (hold_ff.obj_handle != '0)
             && (rd_data_ff.handle == hold_ff.obj_handle)
             && (rd_data_ff.kind == hold_ff.entry_kind);
   assign free_here = cmp_vld_ff && !valid_ff[cmp_idx_ff];
   assign last_cmp  = cmp_vld_ff && (({1'b0, cmp_idx_ff} + CNT_W'(1)) == fill_ff);
   assign issue     = (scan_addr_ff < fill_ff);

   always_comb begin
      state_in     = state_ff;
      hold_in      = hold_ff;
      valid_in     = valid_ff;
      fill_in      = fill_ff;
      scan_addr_in = scan_addr_ff;
      cmp_idx_in   = scan_addr_ff[IDX_W-1:0];
      have_free_in = have_free_ff;
      free_slot_in = free_slot_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      wr_en        = 1'b0;
      wr_addr      = free_slot_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hold_in      = req_data;
               scan_addr_in = '0;
               have_free_in = 1'b0;
               free_slot_in = '0;
               case (req_data.opcode)
                  OP_STORE: state_in = (fill_ff == '0) ? ST_FINISH : ST_SCAN;
                  OP_LOAD:  state_in = ST_LOAD;
                  OP_CLEAR: begin
                     valid_in     = '0;
                     fill_in      = '0;
                     rsp_valid_in = 1'b1;
                     rsp_in.status = STS_OK;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = STS_BAD_INDEX;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue) begin
               scan_addr_in = scan_addr_ff + CNT_W'(1);
            end
            if (hit) begin
               rsp_valid_in    = 1'b1;
               rsp_in.status   = STS_OK;
               rsp_in.slot_out = 6'(cmp_idx_ff);
               state_in        = ST_IDLE;
            end else begin
               if (free_here && !have_free_ff) begin
                  have_free_in = 1'b1;
                  free_slot_in = cmp_idx_ff;
               end
               if (last_cmp) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (have_free_ff) begin
               wr_en                 = 1'b1;
               wr_addr               = free_slot_ff;
               valid_in[free_slot_ff] = 1'b1;
               rsp_in.status         = STS_OK;
               rsp_in.slot_out       = 6'(free_slot_ff);
            end else if (fill_ff == CNT_W'(TABLE_DEPTH)) begin
               rsp_in.status = STS_FULL;
            end else begin
               wr_en                           = 1'b1;
               wr_addr                         = fill_ff[IDX_W-1:0];
               valid_in[fill_ff[IDX_W-1:0]]    = 1'b1;
               fill_in                         = fill_ff + CNT_W'(1);
               rsp_in.status                   = STS_OK;
               rsp_in.slot_out                 = 6'(fill_ff[IDX_W-1:0]);
            end
         end
         ST_LOAD: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (CNT_W'(hold_ff.slot_index) >= fill_ff) begin
               rsp_in.status = STS_BAD_INDEX;
            end else if (!valid_ff[hold_ff.slot_index[IDX_W-1:0]]) begin
               rsp_in.status = STS_NOT_ALLOC;
            end else begin
               rsp_in.status     = STS_OK;
               rsp_in.handle_out = rd_data_ff.handle;
               rsp_in.kind_out   = rd_data_ff.kind;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // a compare is live only while the scan continues
      cmp_vld_in = (state_ff == ST_SCAN) && (state_in == ST_SCAN) && issue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         fill_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         fill_ff      <= fill_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff      <= hold_in;
      scan_addr_ff <= scan_addr_in;
      cmp_idx_ff   <= cmp_idx_in;
      have_free_ff <= have_free_in;
      free_slot_ff <= free_slot_in;
      rsp_ff       <= rsp_in;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(TABLE_DEPTH))
      else $error("fill count beyond table depth");

   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> ({1'b0, cmp_idx_ff} < fill_ff))
      else $error("scan compare outside used slots");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff != ST_IDLE || accept))
      else $error("result beat without a request in flight");

   a_fill_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !start) |=> $stable(fill_ff))
      else $error("fill count moved while idle");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && state_ff == ST_SCAN) |-> 0)
      else $error("result strobe while a scan is running");

endmodule
